FILE: rtl/core/ray_sphere_intersect_core_defines.svh
// assertion macros for the ray / sphere core
`ifndef RAY_SPHERE_INTERSECT_CORE_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_CORE_DEFINES_SVH

// same-cycle implication
`define RSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rsi_pkg.sv
package rsi_pkg;

  localparam int DISC_W = 100;
  localparam int ROOT_W = 50;
  localparam int REM_W  = 52;
  localparam int QUO_W  = 31;

  localparam logic [QUO_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic [DISC_W-1:0] disc;
    logic [31:0]       a;
    logic signed [49:0] h;
    logic              miss;
  } quad_res_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [31:0]       a;
    logic signed [49:0] h;
    logic              miss;
  } root_res_t;

  typedef struct packed {
    logic             hit;
    logic [QUO_W-1:0] distance;
  } isect_res_t;

endpackage

FILE: rtl/core/rsi_ray_if.sv
interface rsi_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        sphere_radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, sphere_radius,
    output ready
  );
endinterface

FILE: rtl/core/rsi_hit_if.sv
interface rsi_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

FILE: rtl/core/rsi_quad.sv
module rsi_quad (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        sphere_radius,
  output logic               out_valid,
  output rsi_pkg::quad_res_t out_res
);
  import rsi_pkg::*;

  logic [6:0] vld;

  logic signed [32:0] d1 [3];
  logic signed [15:0] v1 [3];
  logic [30:0]        r1;

  logic [30:0]        vv2 [3];
  logic signed [48:0] vd2 [3];
  logic [64:0]        dsq2 [3];
  logic [61:0]        rsq2;

  logic [31:0]        a3;
  logic signed [49:0] h3;
  logic [65:0]        dd3;
  logic [61:0]        rsq3;

  logic [66:0]        c4_comb;
  logic [31:0]        a4;
  logic signed [49:0] h4;
  logic [65:0]        cmag4;
  logic [48:0]        hmag4;
  logic               cneg4;
  logic               az4;

  logic [63:0]        p0_5;
  logic [48:0]        p1_5;
  logic [33:0]        p2_5;
  logic [64:0]        q0_5;
  logic [64:0]        q1_5;
  logic [31:0]        a5;
  logic signed [49:0] h5;
  logic               cneg5;
  logic               az5;

  logic [97:0]        hh6;
  logic [97:0]        ac6;
  logic [31:0]        a6;
  logic signed [49:0] h6;
  logic               cneg6;
  logic               az6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  // offset from center
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= 33'(origin_x) - 33'(center_x);
      d1[1] <= 33'(origin_y) - 33'(center_y);
      d1[2] <= 33'(origin_z) - 33'(center_z);
      v1[0] <= dir_x;
      v1[1] <= dir_y;
      v1[2] <= dir_z;
      r1    <= sphere_radius;
    end
  end

  // per-axis products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        vv2[k]  <= 31'(32'(v1[k]) * 32'(v1[k]));
        vd2[k]  <= 49'(d1[k]) * 49'(v1[k]);
        dsq2[k] <= 65'(66'(d1[k]) * 66'(d1[k]));
      end
      rsq2 <= 62'(r1) * 62'(r1);
    end
  end

  // dot products
  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= 32'(vv2[0]) + 32'(vv2[1]) + 32'(vv2[2]);
      h3   <= 50'(vd2[0]) + 50'(vd2[1]) + 50'(vd2[2]);
      dd3  <= 66'(dsq2[0]) + 66'(dsq2[1]) + 66'(dsq2[2]);
      rsq3 <= rsq2;
    end
  end

  assign c4_comb = {1'b0, dd3} - 67'(rsq3);

  // magnitudes of c and h
  always_ff @(posedge clk) begin
    if (en) begin
      cneg4 <= c4_comb[66];
      cmag4 <= c4_comb[66] ? 66'(-c4_comb) : c4_comb[65:0];
      hmag4 <= h3[49] ? 49'(-h3) : h3[48:0];
      a4    <= a3;
      h4    <= h3;
      az4   <= (a3 == '0);
    end
  end

  // partial products of h*h and a*|c|
  always_ff @(posedge clk) begin
    if (en) begin
      p0_5  <= 64'(hmag4[31:0]) * 64'(hmag4[31:0]);
      p1_5  <= 49'(hmag4[31:0]) * 49'(hmag4[48:32]);
      p2_5  <= 34'(hmag4[48:32]) * 34'(hmag4[48:32]);
      q0_5  <= 65'(a4) * 65'(cmag4[32:0]);
      q1_5  <= 65'(a4) * 65'(cmag4[65:33]);
      a5    <= a4;
      h5    <= h4;
      cneg5 <= cneg4;
      az5   <= az4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh6   <= 98'(p0_5) + (98'(p1_5) << 33) + (98'(p2_5) << 64);
      ac6   <= 98'(q0_5) + (98'(q1_5) << 33);
      a6    <= a5;
      h6    <= h5;
      cneg6 <= cneg5;
      az6   <= az5;
    end
  end

  // discriminant
  always_ff @(posedge clk) begin
    if (en) begin
      out_res.a <= a6;
      out_res.h <= h6;
      if (cneg6) begin
        out_res.disc <= DISC_W'(hh6) + DISC_W'(ac6);
        out_res.miss <= az6;
      end else begin
        out_res.disc <= DISC_W'(hh6 - ac6);
        out_res.miss <= az6 | (hh6 < ac6);
      end
    end
  end

  assign out_valid = vld[6];

endmodule

FILE: rtl/core/rsi_sqrt.sv
module rsi_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  rsi_pkg::quad_res_t in_res,
  output logic               out_valid,
  output rsi_pkg::root_res_t out_res
);
  import rsi_pkg::*;

  logic [ROOT_W:0]    vld;
  logic [DISC_W-1:0]  x    [ROOT_W+1];
  logic [REM_W-1:0]   rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  root [ROOT_W+1];
  logic [31:0]        a    [ROOT_W+1];
  logic signed [49:0] h    [ROOT_W+1];
  logic [ROOT_W:0]    miss;

  always_comb begin
    vld[0]  = in_valid;
    x[0]    = in_res.disc;
    rem[0]  = '0;
    root[0] = '0;
    a[0]    = in_res.a;
    h[0]    = in_res.h;
    miss[0] = in_res.miss;
  end

  // one root bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem_sh = {rem[j][REM_W-3:0], x[j][DISC_W-1:DISC_W-2]};
    assign trial  = {root[j], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[j+1]    <= x[j] << 2;
        rem[j+1]  <= ge ? rem_sh - trial : rem_sh;
        root[j+1] <= {root[j][ROOT_W-2:0], ge};
        a[j+1]    <= a[j];
        h[j+1]    <= h[j];
        miss[j+1] <= miss[j];
      end
    end
  end

  assign out_valid    = vld[ROOT_W];
  assign out_res.root = root[ROOT_W];
  assign out_res.a    = a[ROOT_W];
  assign out_res.h    = h[ROOT_W];
  assign out_res.miss = miss[ROOT_W];

endmodule

FILE: rtl/core/rsi_div.sv
module rsi_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  rsi_pkg::root_res_t  in_res,
  output logic                out_valid,
  output rsi_pkg::isect_res_t out_res
);
  import rsi_pkg::*;

  logic signed [51:0] nearr;
  logic signed [51:0] farr;

  logic               vld_sel;
  logic [50:0]        n_sel;
  logic [31:0]        a_sel;
  logic               miss_sel;

  logic [QUO_W:0]     vld;
  logic [31:0]        rem  [QUO_W+1];
  logic [QUO_W-1:0]   x    [QUO_W+1];
  logic [QUO_W-1:0]   quo  [QUO_W+1];
  logic [31:0]        a    [QUO_W+1];
  logic [QUO_W:0]     sat;
  logic [QUO_W:0]     miss;

  logic               vld_out;

  assign nearr = -52'(in_res.h) - $signed(52'(in_res.root));
  assign farr  = -52'(in_res.h) + $signed(52'(in_res.root));

  // pick the nearest root in front of the origin
  always_ff @(posedge clk) begin
    if (en) begin
      n_sel    <= nearr[51] ? farr[50:0] : nearr[50:0];
      a_sel    <= in_res.a;
      miss_sel <= in_res.miss | (nearr[51] & farr[51]);
    end
  end

  // overflow test and divider setup
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0]  <= (n_sel >= 51'({a_sel, 17'b0}));
      rem[0]  <= n_sel[48:17];
      x[0]    <= {n_sel[16:0], 14'b0};
      quo[0]  <= '0;
      a[0]    <= a_sel;
      miss[0] <= miss_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sel <= 1'b0;
      vld[0]  <= 1'b0;
    end else if (en) begin
      vld_sel <= in_valid;
      vld[0]  <= vld_sel;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;

    assign rem_sh = {rem[j], x[j][QUO_W-1]};
    assign diff   = rem_sh - {1'b0, a[j]};
    assign ge     = (rem_sh >= {1'b0, a[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? diff[31:0] : rem_sh[31:0];
        x[j+1]    <= x[j] << 1;
        quo[j+1]  <= {quo[j][QUO_W-2:0], ge};
        a[j+1]    <= a[j];
        sat[j+1]  <= sat[j];
        miss[j+1] <= miss[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.hit <= !miss[QUO_W];
      if (miss[QUO_W]) begin
        out_res.distance <= '0;
      end else if (sat[QUO_W]) begin
        out_res.distance <= DIST_MAX;
      end else begin
        out_res.distance <= quo[QUO_W];
      end
    end
  end

  assign out_valid = vld_out;

endmodule

FILE: rtl/core/ray_sphere_intersect_core.sv
// Ray / sphere intersection: one ray per cycle in on ray while ray.ready is high, one result per
// ray out on isect, in order. 7 stages form the quadratic (offset, products, dot products,
// magnitudes, split partial products, their sums, discriminant), 50 stages take the square
// root of the 100-bit discriminant one bit at a time, and 34 stages pick the near root and
// divide it by a, one quotient bit per stage. A single skid register at the
// output holds a result while isect is stalled; ray.ready drops only while that register is
// full, and then the whole pipeline holds. A zero direction, a negative discriminant or
// both roots behind the origin give hit 0 and distance 0; far distances saturate.
`include "ray_sphere_intersect_core_defines.svh"

module ray_sphere_intersect_core (
  input logic       clk,
  input logic       rst,
  rsi_ray_if.sink   ray,
  rsi_hit_if.source isect
);
  import rsi_pkg::*;

  logic       en;
  logic       quad_valid;
  quad_res_t  quad_res;
  logic       root_valid;
  root_res_t  root_res;
  logic       last_valid;
  isect_res_t last_res;
  logic       skid_valid;
  isect_res_t skid_res;

  assign en        = !skid_valid;
  assign ray.ready = en;

  rsi_quad u_quad (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (ray.valid),
    .origin_x      (ray.origin_x),
    .origin_y      (ray.origin_y),
    .origin_z      (ray.origin_z),
    .dir_x         (ray.dir_x),
    .dir_y         (ray.dir_y),
    .dir_z         (ray.dir_z),
    .center_x      (ray.center_x),
    .center_y      (ray.center_y),
    .center_z      (ray.center_z),
    .sphere_radius (ray.sphere_radius),
    .out_valid     (quad_valid),
    .out_res       (quad_res)
  );

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quad_valid),
    .in_res    (quad_res),
    .out_valid (root_valid),
    .out_res   (root_res)
  );

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_res    (root_res),
    .out_valid (last_valid),
    .out_res   (last_res)
  );

  // skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid && isect.ready) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid && last_valid && !isect.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && last_valid && !isect.ready) begin
      skid_res <= last_res;
    end
  end

  assign isect.valid        = skid_valid || last_valid;
  assign isect.hit          = skid_valid ? skid_res.hit : last_res.hit;
  assign isect.hit_distance = skid_valid ? skid_res.distance : last_res.distance;

  `RSI_ASSERT_NOW(a_ready_skid, skid_valid, !ray.ready, "ray taken while skid full")
  `RSI_ASSERT_NEXT(a_skid_hold, skid_valid && !isect.ready, skid_valid, "skid item lost")
  `RSI_ASSERT_NEXT(a_pipe_hold, skid_valid && last_valid, last_valid, "stalled item lost")
  `RSI_ASSERT_NOW(a_miss_zero, isect.valid && !isect.hit, isect.hit_distance == '0,
                  "miss with nonzero distance")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import rsi_pkg::*;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        rad;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [30:0] distance;
  } hit_t;

  function automatic hit_t solve_sphere(ray_t r);
    logic signed [159:0] dx, dy, dz, vx, vy, vz, a, h, rr, c, disc;
    logic signed [159:0] s, cand, one, nr, fr, n, q, rem, t;
    hit_t res;
    res.hit = 1'b0;
    res.distance = '0;
    dx = r.ox - r.cx;
    dy = r.oy - r.cy;
    dz = r.oz - r.cz;
    vx = r.dx;
    vy = r.dy;
    vz = r.dz;
    rr = {129'b0, r.rad};
    a = vx * vx + vy * vy + vz * vz;
    if (a == 0) return res;
    h = vx * dx + vy * dy + vz * dz;
    c = dx * dx + dy * dy + dz * dz - rr * rr;
    disc = h * h - a * c;
    if (disc < 0) return res;
    s = 0;
    one = 1;
    for (int i = 63; i >= 0; i--) begin
      cand = s | (one <<< i);
      if (cand * cand <= disc) s = cand;
    end
    nr = -h - s;
    fr = -h + s;
    if (nr >= 0) n = nr;
    else if (fr >= 0) n = fr;
    else return res;
    q = n / a;
    rem = n % a;
    if (q >= (one <<< 17)) begin
      t = 160'sh7FFFFFFF;
    end else begin
      t = (q <<< 14) + ((rem <<< 14) / a);
      if (t > 160'sh7FFFFFFF) t = 160'sh7FFFFFFF;
    end
    res.hit = 1'b1;
    res.distance = t[30:0];
    return res;
  endfunction

  class hit_scoreboard;
    hit_t expected_hits[$];
    int errors = 0;

    function void note_ray(ray_t r);
      expected_hits.push_back(solve_sphere(r));
    endfunction

    function void check_hit(logic hit, logic [30:0] distance);
      hit_t e;
      if (expected_hits.size() == 0) begin
        $error("unexpected result item hit=%0d hit_distance=%0d", hit, distance);
        errors++;
        return;
      end
      e = expected_hits.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, hit);
        errors++;
      end
      if (distance !== e.distance) begin
        $error("hit_distance: expected %0d actual %0d", e.distance, distance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  rsi_ray_if ray_ch();
  rsi_hit_if hit_ch();
  hit_scoreboard sb = new();
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_cycles = 0;

  ray_sphere_intersect_core uut (.clk(clk), .rst(rst), .ray(ray_ch), .isect(hit_ch));

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.dir_x = '0;
    ray_ch.dir_y = '0;
    ray_ch.dir_z = '0;
    ray_ch.center_x = '0;
    ray_ch.center_y = '0;
    ray_ch.center_z = '0;
    ray_ch.sphere_radius = '0;
    hit_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (hit_ch.valid && hit_ch.ready) sb.check_hit(hit_ch.hit, hit_ch.hit_distance);
      if (hold_cycles > 0) begin
        hit_ch.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        hit_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  task automatic send_ray(ray_t r);
    while ($urandom_range(0, 99) < snd_idle) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= r.ox;
    ray_ch.origin_y <= r.oy;
    ray_ch.origin_z <= r.oz;
    ray_ch.dir_x <= r.dx;
    ray_ch.dir_y <= r.dy;
    ray_ch.dir_z <= r.dz;
    ray_ch.center_x <= r.cx;
    ray_ch.center_y <= r.cy;
    ray_ch.center_z <= r.cz;
    ray_ch.sphere_radius <= r.rad;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    sb.note_ray(r);
  endtask

  function automatic ray_t mk(int ox, int oy, int oz, shortint dx, shortint dy, shortint dz,
                              int cx, int cy, int cz, int rad);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    r.cx = cx; r.cy = cy; r.cz = cz;
    r.rad = rad[30:0];
    return r;
  endfunction

  function automatic shortint rand_dir();
    return shortint'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    longint t;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      r = mk($urandom, $urandom, $urandom, rand_dir(), rand_dir(), rand_dir(),
             $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 4) begin
      r = mk($signed($urandom) >>> 8, $signed($urandom) >>> 8, $signed($urandom) >>> 8,
             rand_dir(), rand_dir(), rand_dir(),
             $signed($urandom) >>> 8, $signed($urandom) >>> 8, $signed($urandom) >>> 8,
             $urandom_range(0, 1 << 24));
    end else begin
      // aim the sphere along the ray with some jitter
      r.ox = $signed($urandom) >>> 8;
      r.oy = $signed($urandom) >>> 8;
      r.oz = $signed($urandom) >>> 8;
      if ($urandom_range(0, 3) == 0) begin
        r.dx = 0; r.dy = 0; r.dz = 0;
        case ($urandom_range(0, 2))
          0: r.dx = $urandom_range(0, 1) ? 16384 : -16384;
          1: r.dy = $urandom_range(0, 1) ? 16384 : -16384;
          default: r.dz = $urandom_range(0, 1) ? 16384 : -16384;
        endcase
      end else begin
        r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
      end
      t = longint'($urandom_range(0, 1 << 22)) - ($urandom_range(0, 4) == 0 ? (1 << 21) : 0);
      r.cx = r.ox + int'((longint'(r.dx) * t) >>> 14) + int'($urandom_range(0, 4095)) - 2048;
      r.cy = r.oy + int'((longint'(r.dy) * t) >>> 14) + int'($urandom_range(0, 4095)) - 2048;
      r.cz = r.oz + int'((longint'(r.dz) * t) >>> 14) + int'($urandom_range(0, 4095)) - 2048;
      r.rad = $urandom_range(0, 1 << 20);
    end
    return r;
  endfunction

  initial begin
    ray_t dirs[$];
    int one_u;
    one_u = 1 << 16;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle = 22;
    rcv_idle = 81;
    // zero direction
    dirs.push_back(mk(0, 0, 0, 0, 0, 0, 5 * one_u, 0, 0, one_u));
    // plain front hit, unit axis
    dirs.push_back(mk(0, 0, 0, 16384, 0, 0, 5 * one_u, 0, 0, one_u));
    dirs.push_back(mk(0, 0, 0, 0, -16384, 0, 0, -7 * one_u, 0, 2 * one_u));
    dirs.push_back(mk(0, 0, 0, 0, 0, 16384, one_u, one_u, 9 * one_u, 3 * one_u));
    // negative discriminant
    dirs.push_back(mk(0, 0, 0, 16384, 0, 0, 5 * one_u, 4 * one_u, 0, one_u));
    // sphere behind
    dirs.push_back(mk(0, 0, 0, 16384, 0, 0, -5 * one_u, 0, 0, one_u));
    // tangent in front and behind
    dirs.push_back(mk(0, 0, 0, 16384, 0, 0, 5 * one_u, one_u, 0, one_u));
    dirs.push_back(mk(0, 0, 0, 16384, 0, 0, -5 * one_u, one_u, 0, one_u));
    // origin inside
    dirs.push_back(mk(0, 0, 0, 0, 16384, 0, 0, 0, 0, 3 * one_u));
    dirs.push_back(mk(one_u, 0, 0, -16384, 0, 0, 0, 0, 0, 10 * one_u));
    // zero radius on the ray
    dirs.push_back(mk(0, 0, 0, 16384, 0, 0, 5 * one_u, 0, 0, 0));
    // non-unit direction
    dirs.push_back(mk(0, 0, 0, 100, 0, 0, 5 * one_u, 0, 0, one_u));
    dirs.push_back(mk(0, 0, 0, 16384, 16384, 16384, 9 * one_u, 9 * one_u, 9 * one_u, one_u));
    // saturated distance
    dirs.push_back(mk(32'sh80000000, 0, 0, 16384, 0, 0, 32'sh7FFFFFFF, 0, 0, one_u));
    dirs.push_back(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 16384, 16384, 16384,
                      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'h7FFFFFFF));
    // extremes of the fields
    dirs.push_back(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -16384, -16384, -16384,
                      32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h7FFFFFFF));
    dirs.push_back(mk(32'sh7FFFFFFF, 32'sh80000000, 0, -16384, 16384, 1,
                      32'sh7FFFFFFF, 32'sh80000000, 0, 32'h7FFFFFFF));
    dirs.push_back(mk(-1, -1, -1, -1, -1, -1, 0, 0, 0, 1));
    dirs.push_back(mk(0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    foreach (dirs[i]) send_ray(dirs[i]);
    repeat (300) send_ray(rand_ray());

    // long output stall while rays keep coming
    hold_cycles = 400;
    snd_idle = 0;
    repeat (150) send_ray(rand_ray());
    ray_ch.valid <= 1'b0;
    wait (sb.expected_hits.size() == 0);
    @(posedge clk);

    snd_idle = 81;
    rcv_idle = 22;
    repeat (250) send_ray(rand_ray());
    snd_idle = 0;
    rcv_idle = 0;
    repeat (250) send_ray(rand_ray());
    ray_ch.valid <= 1'b0;
    wait (sb.expected_hits.size() == 0);
    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
